/* design/tscc_pkg.sv */
// ----------------------------------------------------------------------------
// tscc_pkg: shared constants and functions for the scratchpad CRC checker
// Holds the frame layout, the CRC-8 polynomial, the one-byte CRC update and
// the whole-degree temperature conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package tscc_pkg;

   // Frame layout: bytes 0..CRC_BYTES-1 feed the CRC, byte LAST_POS is the check
   localparam int unsigned POS_W     = 4;
   localparam logic [POS_W-1:0] CRC_BYTES = 4'd8;
   localparam logic [POS_W-1:0] LAST_POS  = 4'd8;

   // Reflected Dallas/Maxim CRC-8
   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam int unsigned TEMP_W     = 9;
   localparam int unsigned CRC_W      = 8;
   localparam int unsigned RSP_DATA_W = 24;

   // Advance the CRC by one byte, LSB first
   function automatic logic [7:0] crc_byte_update(input logic [7:0] crc_cur,
                                                  input logic [7:0] data_in);
      logic [7:0] crc_v;
      logic [7:0] dat_v;
      logic       fb;
      crc_v = crc_cur;
      dat_v = data_in;
      for (int k = 0; k < 8; k++) begin
         fb    = crc_v[0] ^ dat_v[0];
         crc_v = {1'b0, crc_v[7:1]};
         if (fb) begin
            crc_v = crc_v ^ CRC_POLY;
         end
         dat_v = {1'b0, dat_v[7:1]};
      end
      return crc_v;
   endfunction

   // Word = {hi, lo} << 3 truncated to 16 bits, divided by 128 toward zero.
   // The quotient floor is word[15:7]; bump by one when negative and inexact.
   function automatic logic [TEMP_W-1:0] temp_whole_deg(input logic [7:0] lo,
                                                        input logic [7:0] hi);
      logic [TEMP_W-1:0] floor_q;
      logic              round_up;
      floor_q  = {hi[4:0], lo[7:4]};
      round_up = hi[4] && (lo[3:0] != 4'd0);
      return floor_q + {{(TEMP_W-1){1'b0}}, round_up};
   endfunction

endpackage

`default_nettype wire

/* design/temp_scratchpad_crc_checker_top.sv */
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_checker_top: one-wire sensor scratchpad CRC checker
// Takes the nine scratchpad bytes one beat at a time, runs CRC-8 over the
// data bytes, keeps the temperature word and reports one result per frame.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser
//  req_    | in  | [7:0] data_byte                     | start_req
//  rsp_    | out | [8:0] temperature_c, [16:9] crc     | crc_ok
//
//  One byte per cycle. Each byte updates the frame state in the cycle it is
//  accepted; the ninth byte loads the result register, which shows it in the
//  next cycle. A stalled result holds req_tready low only while rsp_tready
//  is low. Synchronous reset clears the frame position, CRC and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module temp_scratchpad_crc_checker_top
   import tscc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] data_byte
   input  wire logic                  req_tuser,  // [0] start_req
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [8:0] temperature_c, [16:9] computed_crc
   output logic                       rsp_tuser   // [0] crc_ok
);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]            crc_ff, crc_in;
   logic [7:0]            lo_ff, lo_in;
   logic [7:0]            hi_ff, hi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  accept;
   logic [POS_W-1:0]      pos_cur;
   logic [7:0]            crc_cur;
   logic                  crc_ok;
   logic [TEMP_W-1:0]     temp_val;

   // Take a beat whenever the result slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // A start flag restarts the frame at this byte
   assign pos_cur  = req_tuser ? '0 : pos_ff;
   assign crc_cur  = req_tuser ? '0 : crc_ff;
   assign crc_ok   = (crc_cur == req_tdata);
   assign temp_val = crc_ok ? temp_whole_deg(lo_ff, hi_ff) : '0;

   // Frame state and result next values
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         if (pos_cur >= LAST_POS) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {{(RSP_DATA_W-TEMP_W-CRC_W){1'b0}}, crc_cur, temp_val};
            rsp_user_in  = crc_ok;
            pos_in       = '0;
            crc_in       = '0;
         end else begin
            crc_in = (pos_cur < CRC_BYTES) ? crc_byte_update(crc_cur, req_tdata) : crc_cur;
            if (pos_cur == '0) begin
               lo_in = req_tdata;
            end
            if (pos_cur == {{(POS_W-1){1'b0}}, 1'b1}) begin
               hi_in = req_tdata;
            end
            pos_in = pos_cur + {{(POS_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // Control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* design/tscc_checker.sv */
// ----------------------------------------------------------------------------
// tscc_checker: port-level checks for the scratchpad CRC checker
// Watches the top level's channels and flags ordering and payload slips.
// ----------------------------------------------------------------------------
`default_nettype none

module tscc_checker
   import tscc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Drop the temperature when the CRC fails
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[TEMP_W-1:0] == '0)
      else $error("temperature nonzero on CRC mismatch");

   // Block input while a result is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result slot full");

   // A new result only follows an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without accepted byte");

   // Reset empties the result slot
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind temp_scratchpad_crc_checker_top tscc_checker u_tscc_checker (.*);

`default_nettype wire
